FILE: src/swg_pkg.sv
// ----------------------------------------------------------------------------
// swg_pkg
// Shared constants, types and arithmetic helpers of the waterfall grid.
// ----------------------------------------------------------------------------
package swg_pkg;

  localparam int GridSize = 64;
  localparam int RowW     = $clog2(GridSize);
  localparam int CellW    = 2 * RowW;
  localparam int HeightW  = 17;
  localparam int VelW     = 18;
  localparam int ColorW   = 6;
  localparam int BinW     = 16;
  localparam int RgbW     = 24;
  localparam int NumPal   = 5;
  localparam int CfgIdxW  = 3;
  localparam int CellDataW = HeightW + VelW + ColorW;

  localparam logic [CfgIdxW-1:0] CfgPalLast = 3'd4;

  typedef struct packed {
    logic [HeightW-1:0]       height;
    logic signed [VelW-1:0]   vel;
    logic [ColorW-1:0]        color;
  } cell_t;

  typedef struct packed {
    logic [5:0]         row;
    logic [HeightW-1:0] height;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic               last;
  } result_t;

  typedef struct packed {
    logic [5:0]  column;
    logic [BinW-1:0] bin_a;
    logic [BinW-1:0] bin_b;
    logic [BinW-1:0] bin_c;
  } item_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RUN
  } state_e;

  // Scroll one dot by one row: gravity step on height, decay on velocity.
  function automatic cell_t scroll_cell(cell_t c);
    logic signed [23:0] s;
    logic [HeightW-1:0] nh;
    logic [39:0]        prod;
    logic [HeightW-1:0] dec;
    logic signed [19:0] nv;
    cell_t res;
    s = $signed({3'b000, c.height, 4'b0000}) + 24'(c.vel);
    if (s < 0) nh = '0;
    else if (s[23:4] > 20'd131071) nh = 17'h1ffff;
    else nh = s[20:4];
    // floor(nh*4/425) as a multiply by a rounded-up 2^28/425 (exact here).
    prod = 40'(nh) * 40'd631613;
    dec = 17'(prod >> 26);
    nv = 20'(c.vel) - $signed({3'b000, dec});
    if (nv < -20'sd131072) nv = -20'sd131072;
    else if (nv > 20'sd131071) nv = 20'sd131071;
    res.height = nh;
    res.vel    = nv[VelW-1:0];
    res.color  = c.color;
    return res;
  endfunction

endpackage

FILE: src/swg_if.sv
// ----------------------------------------------------------------------------
// swg_in_if / swg_out_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface swg_in_if;
  import swg_pkg::*;
  logic  valid;
  logic  ready;
  item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface swg_out_if;
  import swg_pkg::*;
  logic    valid;
  logic    ready;
  result_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

FILE: src/swg_ram.sv
// ----------------------------------------------------------------------------
// swg_ram
// Single-clock RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module swg_ram #(
  parameter int Depth = 4096,
  parameter int Width = 41
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

FILE: src/swg_color.sv
// ----------------------------------------------------------------------------
// swg_color
// Palette registers and one registered color map lookup.
// ----------------------------------------------------------------------------
module swg_color import swg_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [RgbW-1:0]    cfg_data_i,
  input  logic [ColorW-1:0]  idx_i,
  output logic [RgbW-1:0]    rgb_o
);
  logic [RgbW-1:0] pal_q [NumPal];
  logic [RgbW-1:0] rgb_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumPal; i++) pal_q[i] <= '0;
    end else if (cfg_we_i && cfg_idx_i <= CfgPalLast) begin
      pal_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  always_comb begin
    logic [1:0] t;
    logic [4:0] x;
    logic [12:0] acc;
    t = idx_i[5:4];
    x = {1'b0, idx_i[3:0]};
    for (int ch = 0; ch < 3; ch++) begin
      acc = 13'(5'd16 - x) * 13'(pal_q[3'(t)][ch*8 +: 8])
          + 13'(x) * 13'(pal_q[3'(t) + 3'd1][ch*8 +: 8]);
      rgb_d[ch*8 +: 8] = acc[11:4];
    end
  end

  always_ff @(posedge clk_i) rgb_o <= rgb_d;
endmodule

FILE: src/spectrum_waterfall_grid.sv
// ----------------------------------------------------------------------------
// spectrum_waterfall_grid
// Scrolls one column of a 64x64 falling-dot grid per item and emits its rows.
// ----------------------------------------------------------------------------
// Flow: after the input transfer each row passes the RAM read, the pipeline
// stages and the skid queue; rows leave one per cycle while the result side
// does not stall. The next input is accepted only once the single read port
// of the cell RAM has walked all 64 rows of the column and the queue has
// drained. Reset: the palette clears at once; a clearing pass then zeroes all
// 4096 cells of the cell RAM, during which no input is accepted.
module spectrum_waterfall_grid import swg_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  swg_in_if.sink             in_if,
  swg_out_if.source          out_if,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [RgbW-1:0]    cfg_data_i
);
  state_e state_q, state_d;
  logic [CellW-1:0] clr_q, clr_d;
  logic [RowW:0]    rd_q, rd_d;       // next row to read
  logic [RowW-1:0]  col_q;
  logic [7:0]       level_q;
  logic             rv1_q, rv2_q, rv3_q;
  logic [RowW-1:0]  r1_q, r2_q, r3_q;
  cell_t            prev_q;            // old content of the row just read
  logic [HeightW-1:0] h3_q;
  logic [HeightW-1:0] old_q;
  logic [ColorW-1:0] rcell_color_q;
  logic             hold;
  logic [2:0]       occ;

  logic             we;
  logic [CellW-1:0] waddr, raddr;
  cell_t            wdata, rcell, newc;
  logic [CellDataW-1:0] rdata;
  logic [RgbW-1:0]  rgb;

  // A 4-deep skid queue absorbs the pipeline in flight and drives the output.
  result_t          q_mem [4];
  logic [1:0]       wp_q, rp_q;
  logic [2:0]       cnt_q;
  result_t          res;

  function automatic logic [8:0] max3(item_t it);
    logic [BinW-1:0] m;
    m = it.bin_a;
    if (it.bin_b > m) m = it.bin_b;
    if (it.bin_c > m) m = it.bin_c;
    return (m > 16'd255) ? 9'd255 : 9'(m);
  endfunction

  assign rcell = cell_t'(rdata);

  swg_ram #(.Depth(GridSize * GridSize), .Width(CellDataW)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  swg_color u_color (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .idx_i(rcell_color_q), .rgb_o(rgb)
  );

  // Hold the row walk while the queue and the rows in flight would overfill
  // the four queue entries.
  assign occ  = cnt_q + 3'(rv1_q) + 3'(rv2_q) + 3'(rv3_q);
  assign hold = (occ >= 3'd4) && !(out_if.valid && out_if.ready);

  // Next state.
  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    rd_d    = rd_q;
    unique case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (&clr_q) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_if.valid) begin
          state_d = ST_RUN;
          rd_d = '0;
        end
      end
      ST_RUN: begin
        if (!hold) begin
          if (rd_q <= (RowW+1)'(GridSize - 1)) rd_d = rd_q + 1'b1;
          else if (!rv1_q && !rv2_q && !rv3_q && cnt_q == 3'd0) state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign in_if.ready = (state_q == ST_IDLE);
  assign raddr = {rd_q[RowW-1:0], col_q};

  // Stage 1 has row r1 read data; compute what row r1 holds after update:
  // row 0 gets the new level, row r gets the scroll of old row r-1.
  always_comb begin
    logic [HeightW-1:0] nh0;
    logic               neg;
    logic [HeightW-1:0] mag;
    logic [37:0]        prod;
    logic [VelW-1:0]    q;
    nh0  = {1'b0, level_q, 8'h00};
    neg  = (rcell.height > nh0);
    mag  = neg ? (rcell.height - nh0) : (nh0 - rcell.height);
    // |d|*16/90 = |d|*8/45, by a multiply with a rounded-up 2^26/45.
    prod = 38'(mag) * 38'd1491309;
    q    = VelW'(prod >> 23);
    if (r1_q == '0) begin
      newc.height = nh0;
      newc.vel    = neg ? -q : q;
      newc.color  = (level_q[7:2] > 6'd63) ? 6'd63 : level_q[7:2];
    end else begin
      newc = scroll_cell(prev_q);
    end
  end

  assign we    = (state_q == ST_CLEAR) || rv1_q;
  assign waddr = (state_q == ST_CLEAR) ? clr_q : {r1_q, col_q};
  assign wdata = (state_q == ST_CLEAR) ? '0 : newc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      rd_q    <= '0;
      rv1_q   <= 1'b0;
      rv2_q   <= 1'b0;
      rv3_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      rd_q    <= rd_d;
      rv1_q   <= (state_q == ST_RUN) && !hold && (rd_q <= (RowW+1)'(GridSize - 1));
      rv2_q   <= rv1_q;
      rv3_q   <= rv2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) begin
      col_q   <= in_if.data.column;
      level_q <= 8'(max3(in_if.data));
    end
    r1_q <= rd_q[RowW-1:0];
    if (rv1_q) begin
      prev_q <= rcell;
      rcell_color_q <= newc.color;
      h3_q <= newc.height;
    end
    r2_q <= r1_q;
    old_q <= h3_q;
    r3_q <= r2_q;
  end

  // Result assembly: rgb arrives in the cycle after the color index.
  always_comb begin
    res.row    = r3_q;
    res.height = old_q;
    res.red    = rgb[23:16];
    res.green  = rgb[15:8];
    res.blue   = rgb[7:0];
    res.last   = (r3_q == RowW'(GridSize - 1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      if (rv3_q) wp_q <= wp_q + 1'b1;
      if (out_if.valid && out_if.ready) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + 3'(rv3_q) - 3'(out_if.valid && out_if.ready);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rv3_q) q_mem[wp_q] <= res;
  end

  assign out_if.valid = (cnt_q != 3'd0);
  assign out_if.data  = q_mem[rp_q];
endmodule

FILE: src/swg_checker.sv
// ----------------------------------------------------------------------------
// swg_checker
// Port-level checks on the waterfall grid, bound to the top level.
// ----------------------------------------------------------------------------
module swg_checker import swg_pkg::*; (
  input logic    clk_i,
  input logic    rst_ni,
  input logic    in_valid,
  input logic    in_ready,
  input logic    out_valid,
  input logic    out_ready,
  input result_t out_data
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");
  a_last_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (out_data.last == (out_data.row == 6'd63)))
    else $error("last flag mismatch");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> !in_ready)
    else $error("input taken while results pending");
endmodule

bind spectrum_waterfall_grid swg_checker u_swg_checker (
  .clk_i, .rst_ni,
  .in_valid(in_if.valid), .in_ready(in_if.ready),
  .out_valid(out_if.valid), .out_ready(out_if.ready), .out_data(out_if.data)
);
